@@ rtl/skm_pkg.sv @@
// Shared types and constants for the scanned key matrix unit.
// Used by every module in rtl; depends on nothing.
package skm_pkg;

  localparam int MATRIX_ROWS = 8;
  localparam int OUT_WIDTH = 8;
  localparam int ROW_CNT_W = 4;
  localparam int SCAN_W = 8;

  localparam logic [2:0] CMD_MATRIX_KEY = 3'd0;
  localparam logic [2:0] CMD_SHIFT_KEY = 3'd1;
  localparam logic [2:0] CMD_CTRL_KEY = 3'd2;
  localparam logic [2:0] CMD_RUSLAT_KEY = 3'd3;
  localparam logic [2:0] CMD_SCAN_WRITE = 3'd4;
  localparam logic [2:0] CMD_LED_WRITE = 3'd5;

  localparam logic [1:0] FORCE_KEEP = 2'd0;
  localparam logic [1:0] FORCE_RELEASE = 2'd1;
  localparam logic [1:0] FORCE_PRESS = 2'd2;

  typedef logic [OUT_WIDTH-1:0] row_t;

  typedef struct packed {
    logic [2:0]        command;
    logic              pressed;
    logic [2:0]        row_index;
    logic [2:0]        bit_index;
    logic [1:0]        forced_shift;
    logic [SCAN_W-1:0] scan_value;
    logic              led_value;
  } item_t;

  typedef struct packed {
    row_t matrix_out;
    logic shift_line;
    logic ctrl_line;
    logic ruslat_line;
    logic russian_mode;
  } result_t;

  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

@@ rtl/skm_in_stage.sv @@
// Input register of the scanned key matrix unit.
// Depends on skm_pkg for the item type and the stage control struct.
module skm_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  skm_pkg::item_t      in_item,
  input  skm_pkg::stage_ctl_t ctl_in,
  output skm_pkg::stage_ctl_t ctl_out,
  output skm_pkg::item_t      item
);
  import skm_pkg::*;

  logic valid;

  assign in_ready = !valid || ctl_in.take;
  assign ctl_out.valid = valid;
  assign ctl_out.take = ctl_in.take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

@@ rtl/skm_core.sv @@
// Key matrix state, item update and answer logic with the result register.
// Depends on skm_pkg for types, command codes and matrix dimensions.
module skm_core (
  input  logic                     clk,
  input  logic                     rst,
  input  skm_pkg::stage_ctl_t      ctl_in,
  output skm_pkg::stage_ctl_t      ctl_out,
  input  skm_pkg::item_t           item,
  input  logic                     cfg_valid,
  input  logic [skm_pkg::ROW_CNT_W-1:0] cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output skm_pkg::result_t         result
);
  import skm_pkg::*;

  row_t              matrix_rows [MATRIX_ROWS];
  row_t              matrix_rows_next [MATRIX_ROWS];
  logic [SCAN_W-1:0] scan_latch, scan_latch_next;
  logic              saved_shift, saved_shift_next;
  logic              shift_level, shift_level_next;
  logic              ctrl_level, ctrl_level_next;
  logic              ruslat_level, ruslat_level_next;
  logic              alphabet_mode, alphabet_mode_next;
  logic              led_seen_valid, led_seen_valid_next;
  logic              led_seen, led_seen_next;
  logic              led_applied_valid, led_applied_valid_next;
  logic              led_applied, led_applied_next;
  logic [ROW_CNT_W-1:0] scan_rows_used;
  logic              take;
  logic              key_ok;
  row_t              answer;

  assign take = ctl_in.valid && (!out_valid || out_ready);
  assign ctl_out.valid = ctl_in.valid;
  assign ctl_out.take = !out_valid || out_ready;

  assign key_ok = (int'(item.row_index) < MATRIX_ROWS) && (int'(item.bit_index) < OUT_WIDTH);

  always_comb begin
    for (int i = 0; i < MATRIX_ROWS; i++) begin
      matrix_rows_next[i] = matrix_rows[i];
    end
    scan_latch_next = scan_latch;
    saved_shift_next = saved_shift;
    shift_level_next = shift_level;
    ctrl_level_next = ctrl_level;
    ruslat_level_next = ruslat_level;
    alphabet_mode_next = alphabet_mode;
    led_seen_valid_next = led_seen_valid;
    led_seen_next = led_seen;
    led_applied_valid_next = led_applied_valid;
    led_applied_next = led_applied;
    unique case (item.command)
      CMD_MATRIX_KEY: begin
        if (key_ok) begin
          for (int i = 0; i < MATRIX_ROWS; i++) begin
            if (int'(item.row_index) == i) begin
              matrix_rows_next[i][item.bit_index] = !item.pressed;
            end
          end
          if (item.forced_shift == FORCE_RELEASE || item.forced_shift == FORCE_PRESS) begin
            if (item.pressed) begin
              saved_shift_next = shift_level;
              shift_level_next = (item.forced_shift != FORCE_PRESS);
            end else begin
              shift_level_next = saved_shift;
            end
          end
        end
      end
      CMD_SHIFT_KEY: begin
        shift_level_next = !item.pressed;
        saved_shift_next = !item.pressed;
      end
      CMD_CTRL_KEY: begin
        ctrl_level_next = !item.pressed;
      end
      CMD_RUSLAT_KEY: begin
        ruslat_level_next = !item.pressed;
        if (item.pressed) begin
          alphabet_mode_next = !alphabet_mode;
        end
      end
      CMD_SCAN_WRITE: begin
        scan_latch_next = item.scan_value;
        if (led_seen_valid && (!led_applied_valid || led_seen != led_applied)) begin
          led_applied_valid_next = 1'b1;
          led_applied_next = led_seen;
          alphabet_mode_next = led_seen;
        end
      end
      CMD_LED_WRITE: begin
        led_seen_valid_next = 1'b1;
        led_seen_next = item.led_value;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    answer = '1;
    for (int i = 0; i < MATRIX_ROWS; i++) begin
      if (ROW_CNT_W'(i) < scan_rows_used && !scan_latch_next[i]) begin
        answer = answer & matrix_rows_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MATRIX_ROWS; i++) begin
        matrix_rows[i] <= '1;
      end
      scan_latch <= '1;
      saved_shift <= 1'b1;
      shift_level <= 1'b1;
      ctrl_level <= 1'b1;
      ruslat_level <= 1'b1;
      alphabet_mode <= 1'b0;
      led_seen_valid <= 1'b0;
      led_seen <= 1'b0;
      led_applied_valid <= 1'b0;
      led_applied <= 1'b0;
    end else if (take) begin
      for (int i = 0; i < MATRIX_ROWS; i++) begin
        matrix_rows[i] <= matrix_rows_next[i];
      end
      scan_latch <= scan_latch_next;
      saved_shift <= saved_shift_next;
      shift_level <= shift_level_next;
      ctrl_level <= ctrl_level_next;
      ruslat_level <= ruslat_level_next;
      alphabet_mode <= alphabet_mode_next;
      led_seen_valid <= led_seen_valid_next;
      led_seen <= led_seen_next;
      led_applied_valid <= led_applied_valid_next;
      led_applied <= led_applied_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_rows_used <= ROW_CNT_W'(MATRIX_ROWS);
    end else if (cfg_valid) begin
      scan_rows_used <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.matrix_out <= answer;
      result.shift_line <= shift_level_next;
      result.ctrl_line <= ctrl_level_next;
      result.ruslat_line <= ruslat_level_next;
      result.russian_mode <= alphabet_mode_next;
    end
  end

endmodule

@@ rtl/scanned_key_matrix_unit.sv @@
// Scanned key matrix unit: 8x8 active-low key matrix with Shift, Ctrl and
// Rus/Lat lines. An input word passes the input register, the combinational
// state update and the result register to become a result word; one word is
// taken every cycle unless m_tready stalls the result register. Synchronous
// reset returns all keys released, scan latch all ones and Latin mode at once.
module scanned_key_matrix_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pressed, row_index[2:0], bit_index[2:0], forced_shift[1:0],
  // scan_value[7:0], led_value, zero fill
  input  logic [23:0] s_tdata,
  // command[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // matrix_out[7:0], shift_line, ctrl_line, ruslat_line, russian_mode, zero fill
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);
  import skm_pkg::*;

  item_t      in_item;
  item_t      item;
  result_t    result;
  stage_ctl_t in_ctl;
  stage_ctl_t core_ctl;

  assign in_item.command = s_tuser;
  assign in_item.pressed = s_tdata[0];
  assign in_item.row_index = s_tdata[3:1];
  assign in_item.bit_index = s_tdata[6:4];
  assign in_item.forced_shift = s_tdata[8:7];
  assign in_item.scan_value = s_tdata[16:9];
  assign in_item.led_value = s_tdata[17];

  assign cfg_ready = 1'b1;

  skm_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .ctl_in   (core_ctl),
    .ctl_out  (in_ctl),
    .item     (item)
  );

  skm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (in_ctl),
    .ctl_out   (core_ctl),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  assign m_tdata = {4'b0000, result.russian_mode, result.ruslat_line, result.ctrl_line,
                    result.shift_line, result.matrix_out};

endmodule
